@@ hw/rtl/slilp_pkg.sv @@
// Shared constants, codes and types for the sorted list block.
package slilp_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int VALUE_W   = 64;
    localparam int OP_W      = 2;
    localparam int ST_W      = 2;
    localparam int COUNT_W   = 7;

    localparam logic [OP_W-1:0] OP_INSERT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CONTAINS = 2'd1;
    localparam logic [OP_W-1:0] OP_POP      = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR    = 2'd3;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic                       insert_en;
        logic                       pop_en;
        logic signed [VALUE_W-1:0]  value;
    } cmd_t;

    typedef struct packed {
        logic occ;
        logic gt;
        logic eq;
    } cell_stat_t;

endpackage

@@ hw/rtl/slilp_cell.sv @@
// One storage cell of the sorted chain: holds a value, compares, shifts.
module slilp_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 7
) (
    input  logic                                 clk,
    input  slilp_pkg::cmd_t                      cmd,
    input  logic [CNT_W-1:0]                     count_cur,
    input  logic signed [slilp_pkg::VALUE_W-1:0] left_entry,
    input  slilp_pkg::cell_stat_t                left_stat,
    input  logic signed [slilp_pkg::VALUE_W-1:0] right_entry,
    output logic signed [slilp_pkg::VALUE_W-1:0] entry,
    output slilp_pkg::cell_stat_t                stat
);

    logic signed [slilp_pkg::VALUE_W-1:0] entry_reg;
    logic signed [slilp_pkg::VALUE_W-1:0] entry_next;
    logic                                 occ;
    logic                                 take_new;

    assign occ      = count_cur > CNT_W'(INDEX);
    assign stat.occ = occ;
    assign stat.gt  = occ && (entry_reg > cmd.value);
    assign stat.eq  = occ && (entry_reg == cmd.value);
    assign entry    = entry_reg;

    // new value lands at the first greater entry, or at the first free slot
    assign take_new = !left_stat.gt && (stat.gt || (!occ && left_stat.occ));

    always_comb
    begin
        entry_next = entry_reg;
        priority if (cmd.insert_en)
        begin
            priority if (left_stat.gt)
                entry_next = left_entry;
            else if (take_new)
                entry_next = cmd.value;
            else
                entry_next = entry_reg;
        end
        else if (cmd.pop_en)
        begin
            entry_next = right_entry;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

@@ hw/rtl/sorted_list_insert_lookup_pop.sv @@
// Top level of the sorted list: cell chain, count and result register.
//
// Keeps up to DEPTH signed 64-bit values in ascending order in a chain of
// cells. The input channel (in_valid, in_stall, operation, value) takes an
// item when in_valid is high and in_stall is low. Operations: insert
// (placed after equal values), contains, pop smallest, clear.
// Every item gives exactly one result on the output channel (out_valid,
// out_stall, found, popped_value, status, count), registered in the cycle
// after acceptance. One item is taken every cycle while in_stall is low:
// every cell compares the incoming value and shifts in the same cycle, so
// the chain of cells finishes any operation when the item is taken.
// A full list refuses an insert (status 1); a pop on an empty list gives
// value 0 and status 2. count is the number of stored values afterwards.
// Reset empties the list and drops any pending result; stored words are
// not cleared. While the receiver stalls a waiting result, in_stall is
// raised and the result holds.
module sorted_list_insert_lookup_pop #(
    parameter int DEPTH = slilp_pkg::DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [slilp_pkg::OP_W-1:0]           operation,
    input  logic signed [slilp_pkg::VALUE_W-1:0] value,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 found,
    output logic signed [slilp_pkg::VALUE_W-1:0] popped_value,
    output logic [slilp_pkg::ST_W-1:0]           status,
    output logic [slilp_pkg::COUNT_W-1:0]        count
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CW    = slilp_pkg::COUNT_W;

    logic [CNT_W-1:0]                     count_reg;
    logic [CNT_W-1:0]                     count_next;
    logic                                 out_valid_reg;
    logic                                 out_valid_next;
    logic                                 found_reg;
    logic                                 found_next;
    logic signed [slilp_pkg::VALUE_W-1:0] popped_reg;
    logic signed [slilp_pkg::VALUE_W-1:0] popped_next;
    logic [slilp_pkg::ST_W-1:0]           status_reg;
    logic [slilp_pkg::ST_W-1:0]           status_next;

    logic                                 accept;
    logic                                 full;
    logic                                 empty;
    slilp_pkg::cmd_t                      cmd;
    logic signed [slilp_pkg::VALUE_W-1:0] entry [DEPTH];
    slilp_pkg::cell_stat_t                stat  [DEPTH];
    logic [DEPTH-1:0]                     eq_vec;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign full     = count_reg == CNT_W'(DEPTH);
    assign empty    = count_reg == '0;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic signed [slilp_pkg::VALUE_W-1:0] l_entry;
            logic signed [slilp_pkg::VALUE_W-1:0] r_entry;
            slilp_pkg::cell_stat_t                l_stat;

            if (g == 0)
            begin : g_head
                assign l_entry = '0;
                assign l_stat  = '{occ: 1'b1, gt: 1'b0, eq: 1'b0};
            end
            else
            begin : g_body
                assign l_entry = entry[g-1];
                assign l_stat  = stat[g-1];
            end

            if (g == DEPTH - 1)
            begin : g_tail
                assign r_entry = '0;
            end
            else
            begin : g_next
                assign r_entry = entry[g+1];
            end

            slilp_cell #(
                .INDEX (g),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk         (clk),
                .cmd         (cmd),
                .count_cur   (count_reg),
                .left_entry  (l_entry),
                .left_stat   (l_stat),
                .right_entry (r_entry),
                .entry       (entry[g]),
                .stat        (stat[g])
            );

            assign eq_vec[g] = stat[g].eq;
        end
    endgenerate

    always_comb
    begin
        cmd.insert_en = 1'b0;
        cmd.pop_en    = 1'b0;
        cmd.value     = value;
        count_next    = count_reg;
        found_next    = 1'b0;
        popped_next   = '0;
        status_next   = slilp_pkg::ST_OK;
        unique case (operation)
            slilp_pkg::OP_INSERT:
            begin
                if (full)
                begin
                    status_next = slilp_pkg::ST_FULL;
                end
                else
                begin
                    cmd.insert_en = accept;
                    count_next    = count_reg + 1'b1;
                end
            end
            slilp_pkg::OP_CONTAINS:
            begin
                found_next = |eq_vec;
            end
            slilp_pkg::OP_POP:
            begin
                if (empty)
                begin
                    status_next = slilp_pkg::ST_EMPTY;
                end
                else
                begin
                    cmd.pop_en  = accept;
                    popped_next = entry[0];
                    count_next  = count_reg - 1'b1;
                end
            end
            slilp_pkg::OP_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_comb
    begin
        if (accept)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
                count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            found_reg  <= found_next;
            popped_reg <= popped_next;
            status_reg <= status_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign popped_value = popped_reg;
    assign status       = status_reg;
    assign count        = CW'(count_reg);

endmodule
